// ===== rtl/core/pitched_sample_player_unit_macros.svh =====
// Assertion macros for the sample player RTL.
`ifndef PITCHED_SAMPLE_PLAYER_UNIT_MACROS_SVH
`define PITCHED_SAMPLE_PLAYER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSPU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pspu_pkg.sv =====
// Types, constants and the pitch step function of the sample player.
package pspu_pkg;

  // Default number of stored sample words.
  localparam int unsigned SAMPLE_DEPTH_DEF = 4096;

  // Width of a 16.16 pitch step after the octave shift (up to 123715 << 4).
  localparam int unsigned STEP_W = 21;

  // Step of one stored word per output sample.
  localparam logic [STEP_W-1:0] UNITY_STEP = 21'd65536;

  // Reset values of the configuration registers.
  localparam logic [6:0]  PITCH_NOTE_RST    = 7'd60;
  localparam logic [6:0]  BASE_NOTE_RST     = 7'd60;
  localparam logic [12:0] SAMPLE_LENGTH_RST = 13'd0;
  localparam logic        SOUND_ENABLE_RST  = 1'b1;

  // 2^(n/12) in 16.16 for n = 0 .. 11.
  localparam logic [16:0] SEMITONE_Q16 [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  // Input item kinds, carried on in_tuser.
  typedef enum logic [1:0] {
    OP_RENDER  = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_WRITE   = 2'd2
  } pspu_op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PITCH_NOTE    = 2'd0,
    REG_BASE_NOTE     = 2'd1,
    REG_SAMPLE_LENGTH = 2'd2,
    REG_SOUND_ENABLE  = 2'd3
  } pspu_reg_t;

  // Render request handed from the control to the interpolator.
  typedef struct packed {
    logic        render;
    logic        playing;
    logic [15:0] frac;
  } pspu_req_t;

  // Step for a note pair: semitone table entry shifted by the clamped octave.
  // The note difference is offset by 132 to stay positive, then divided by 12
  // through a multiply by 171/2048, which is exact over the range 5 .. 259.
  function automatic logic [STEP_W-1:0] step_for(logic [6:0] pitch, logic [6:0] base);
    logic [8:0]        x;
    logic [15:0]       prod;
    logic [4:0]        q;
    logic [3:0]        rem;
    logic [STEP_W-1:0] wide;
    logic [STEP_W-1:0] step;
    x    = 9'({2'b00, pitch}) + 9'd132 - 9'({2'b00, base});
    prod = 16'({7'd0, x}) * 16'd171;
    q    = prod[15:11];
    rem  = 4'(x - 9'({4'd0, q}) * 9'd12);
    wide = {4'd0, SEMITONE_Q16[rem]};
    // The octave is q - 11, clamped to plus or minus four.
    if (q >= 5'd15) begin
      step = wide << 4;
    end else if (q >= 5'd11) begin
      step = wide << (q - 5'd11);
    end else if (q >= 5'd7) begin
      step = wide >> (5'd11 - q);
    end else begin
      step = wide >> 4;
    end
    return step;
  endfunction

endpackage

// ===== rtl/core/pspu_store.sv =====
// Sample store: two identical banks so that both neighbouring words read at once.
module pspu_store import pspu_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [15:0]   word_a,
  output logic [15:0]   word_b
);

  logic [15:0] bank_a [SAMPLE_DEPTH];
  logic [15:0] bank_b [SAMPLE_DEPTH];
  logic [15:0] word_a_r;
  logic [15:0] word_b_r;

  // Every write goes to both banks.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_a[wr_addr] <= wr_data;
      bank_b[wr_addr] <= wr_data;
    end
  end

  // Registered reads; the data holds while no render is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      word_a_r <= bank_a[rd_addr_a];
      word_b_r <= bank_b[rd_addr_b];
    end
  end

  assign word_a = word_a_r;
  assign word_b = word_b_r;

endmodule

// ===== rtl/core/pspu_interp.sv =====
// Interpolation pipeline: read stage, product stage and output register.
module pspu_interp import pspu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pspu_req_t   req,
  input  logic [15:0] word_a,
  input  logic [15:0] word_b,
  output logic        s1_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] audio_sample
  output logic        out_tuser   // [0] playing
);

  logic               v1_r, v2_r, v3_r;
  logic               play1_r, play2_r, play3_r;
  logic [15:0]        frac1_r;
  logic signed [15:0] a2_r;
  logic signed [33:0] prod2_r;
  logic [15:0]        audio3_r;
  logic               en1, en2, en3;
  logic signed [16:0] diff;
  logic signed [33:0] prod_nxt;
  logic signed [17:0] sum;

  // Each stage moves on when the one after it is empty or moving.
  assign en3      = !v3_r || out_tready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign s1_ready = en1;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= req.render;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Difference of the neighbouring words times the fraction, full width.
  assign diff     = 17'($signed(word_b)) - 17'($signed(word_a));
  assign prod_nxt = 34'(diff * $signed({1'b0, frac1_r}));

  // Floor division by 65536 is an arithmetic shift; the sum stays in range.
  assign sum = 18'(a2_r) + 18'(prod2_r >>> 16);

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1 && req.render) begin
      play1_r <= req.playing;
      frac1_r <= req.frac;
    end
    if (en2 && v1_r) begin
      play2_r <= play1_r;
      a2_r    <= $signed(word_a);
      prod2_r <= prod_nxt;
    end
    if (en3 && v2_r) begin
      play3_r  <= play2_r;
      audio3_r <= play2_r ? sum[15:0] : 16'd0;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = audio3_r;
  assign out_tuser  = play3_r;

endmodule

// ===== rtl/core/pspu_ctrl.sv =====
// Control: configuration registers, pitch step, play position and store access.
module pspu_ctrl import pspu_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [1:0]    op_code,
  input  logic [11:0]   sample_address,
  input  logic [15:0]   sample_value,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data,
  output pspu_req_t     req,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [15:0]   wr_data,
  output logic [AW-1:0] rd_addr_a,
  output logic [AW-1:0] rd_addr_b
);

  `include "pitched_sample_player_unit_macros.svh"

  localparam logic [16:0] DEPTH_V = 17'(SAMPLE_DEPTH);

  logic [6:0]        pitch_r, pitch_nxt;
  logic [6:0]        base_r, base_nxt;
  logic [12:0]       length_r, length_nxt;
  logic              enable_r, enable_nxt;
  logic [STEP_W-1:0] step_r;
  logic [31:0]       pos_r, pos_nxt;
  pspu_op_t          op;
  logic [16:0]       len_ext, len_eff;
  logic [15:0]       idx;
  logic              silent;
  logic              do_render, do_trigger;

  // Configuration writes.
  always_comb begin
    pitch_nxt  = pitch_r;
    base_nxt   = base_r;
    length_nxt = length_r;
    enable_nxt = enable_r;
    if (cfg_write) begin
      unique case (pspu_reg_t'(cfg_index))
        REG_PITCH_NOTE:    pitch_nxt  = cfg_data[6:0];
        REG_BASE_NOTE:     base_nxt   = cfg_data[6:0];
        REG_SAMPLE_LENGTH: length_nxt = cfg_data;
        REG_SOUND_ENABLE:  enable_nxt = cfg_data[0];
      endcase
    end
  end

  // The step follows the note registers as they are written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r  <= PITCH_NOTE_RST;
      base_r   <= BASE_NOTE_RST;
      length_r <= SAMPLE_LENGTH_RST;
      enable_r <= SOUND_ENABLE_RST;
      step_r   <= UNITY_STEP;
    end else begin
      pitch_r  <= pitch_nxt;
      base_r   <= base_nxt;
      length_r <= length_nxt;
      enable_r <= enable_nxt;
      step_r   <= step_for(pitch_nxt, base_nxt);
    end
  end

  // Item decode.
  assign op         = pspu_op_t'(op_code);
  assign do_render  = accept && (op == OP_RENDER);
  assign do_trigger = accept && (op == OP_TRIGGER) && enable_r;

  // Silent once the position has passed the last pair of words in use.
  assign len_ext = {4'd0, length_r};
  assign len_eff = (len_ext > DEPTH_V) ? DEPTH_V : len_ext;
  assign idx     = pos_r[31:16];
  assign silent  = (len_eff < 17'd2) || ({1'b0, idx} >= len_eff - 17'd1);

  // Play position: a trigger restarts, a sounding render advances.
  always_comb begin
    pos_nxt = pos_r;
    if (do_trigger) begin
      pos_nxt = '0;
    end else if (do_render && !silent) begin
      pos_nxt = pos_r + {11'd0, step_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '1;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Store access: writes beyond the depth are dropped.
  assign wr_en     = accept && (op == OP_WRITE) && ({5'd0, sample_address} < DEPTH_V);
  assign wr_addr   = AW'({5'd0, sample_address});
  assign wr_data   = sample_value;
  assign rd_addr_a = pos_r[16 +: AW];
  assign rd_addr_b = AW'(pos_r[16 +: AW] + 1'b1);

  assign req.render  = do_render;
  assign req.playing = !silent;
  assign req.frac    = pos_r[15:0];

  `PSPU_ASSERT_NEXT(a_silent_holds, clk, rst_n, do_render && silent,
    pos_r == $past(pos_r), "silent render moved the play position")
  `PSPU_ASSERT_NEXT(a_play_advances, clk, rst_n, do_render && !silent,
    pos_r == 32'($past(pos_r) + {11'd0, $past(step_r)}),
    "sounding render did not advance by the step")
  `PSPU_ASSERT_NEXT(a_trigger_restarts, clk, rst_n, do_trigger,
    pos_r == 32'd0, "enabled trigger did not restart playback")

endmodule

// ===== rtl/core/pitched_sample_player_unit.sv =====
// Pitched one-shot sample voice with linear interpolation between stored words.
//
// The in_ stream carries write, trigger and render beats, with the kind on
// in_tuser. A write beat stores one PCM word, a trigger beat restarts
// playback at position zero when sound is enabled, and a render beat gives
// exactly one beat on the out_ stream: the interpolated sample and a flag
// that is set while the sample is sounding. Registers are written on the
// cfg_ port, which is ready whenever reset is released; the user must write
// them only while the block is idle; the block itself does not enforce this. A
// render beat's result passes the store read at the accepting edge, then
// the interpolation product register and the output register, before it
// reaches the out_ stream. One beat of any kind is taken every cycle
// while the output side keeps up. Write and trigger beats give no result.
// When the receiver stalls, the result holds in the output register and the
// stages before it keep filling; in_tready falls once all are full.
// Reset restores the register defaults and leaves playback silent; both
// ready outputs are low while it is held. The sample store is not cleared
// and needs loading before it is played.
module pitched_sample_player_unit import pspu_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] sample_address, [27:12] sample_value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] audio_sample
  output logic        out_tuser,  // [0] playing
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

  pspu_req_t   req;
  logic        accept;
  logic        s1_ready;
  logic        wr_en;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [15:0] wr_data, word_a, word_b;

  // Nothing is taken on either channel while reset is held.
  assign in_tready = s1_ready && rst_n;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  pspu_ctrl #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .op_code        (in_tuser),
    .sample_address (in_tdata[11:0]),
    .sample_value   (in_tdata[27:12]),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req            (req),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b)
  );

  pspu_store #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (req.render),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .word_a    (word_a),
    .word_b    (word_b)
  );

  pspu_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .word_a     (word_a),
    .word_b     (word_b),
    .s1_ready   (s1_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== dv/pspu_checker.sv =====
// Checker for the sample player: watches all three channels, predicts and compares results.
module pspu_checker import pspu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] sample_address, [27:12] sample_value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] audio_sample
  input  logic        out_tuser,  // [0] playing
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = SAMPLE_DEPTH_DEF;

  // Frequency ratios of the twelve semitones of one octave, 16.16.
  localparam int unsigned RATIO_Q16 [12] = '{
    65536, 69433, 73562, 77936, 82570, 87480,
    92682, 98193, 104032, 110218, 116772, 123715
  };

  typedef struct packed {
    logic [15:0] audio;
    logic        playing;
  } voice_sample_t;

  // Shadow copy of the voice: stored words, play position and registers.
  logic [15:0]   wave_mem [DEPTH];
  logic [31:0]   play_pos;
  logic [6:0]    pitch_reg;
  logic [6:0]    base_reg;
  logic [12:0]   length_reg;
  logic          enable_reg;
  voice_sample_t voice_q [$];

  // Position increment per rendered sample for the current pair of notes.
  function automatic logic [31:0] pitch_step(logic [6:0] pitch, logic [6:0] base);
    int          offset;
    int          octave;
    logic [31:0] ratio;
    offset = int'(pitch) - int'(base) + 132;
    octave = offset / 12 - 11;
    ratio  = RATIO_Q16[offset % 12];
    if (octave > 4) octave = 4;
    if (octave < -4) octave = -4;
    return (octave >= 0) ? (ratio << octave) : (ratio >> (-octave));
  endfunction

  // Linear blend of two neighbouring words; the correction rounds towards minus infinity.
  function automatic logic [15:0] blend(logic signed [15:0] lo, logic signed [15:0] hi,
                                        logic [15:0] frac);
    logic signed [16:0] span;
    logic signed [33:0] prod;
    logic signed [33:0] corr;
    span = {hi[15], hi} - {lo[15], lo};
    prod = span * $signed({1'b0, frac});
    corr = prod >>> 16;
    return lo + corr[15:0];
  endfunction

  always @(posedge clk) begin
    voice_sample_t want;
    voice_sample_t got;
    int unsigned   len;
    int unsigned   idx;
    if (!rst_n) begin
      play_pos   = '1;
      pitch_reg  = PITCH_NOTE_RST;
      base_reg   = BASE_NOTE_RST;
      length_reg = SAMPLE_LENGTH_RST;
      enable_reg = SOUND_ENABLE_RST;
      voice_q.delete();
      fail_count = 0;
    end else begin
      // Result beat: compare with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got = '{audio: out_tdata, playing: out_tuser};
        if (voice_q.size() == 0) begin
          $display("%0t: unexpected result beat audio=%h playing=%b",
                   $time, got.audio, got.playing);
          fail_count++;
        end else begin
          want = voice_q.pop_front();
          if (got.audio !== want.audio) begin
            $display("%0t: audio_sample mismatch: expected %h, actual %h",
                     $time, want.audio, got.audio);
            fail_count++;
          end
          if (got.playing !== want.playing) begin
            $display("%0t: playing mismatch: expected %b, actual %b",
                     $time, want.playing, got.playing);
            fail_count++;
          end
        end
      end

      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (pspu_reg_t'(cfg_index))
          REG_PITCH_NOTE:    pitch_reg  = cfg_data[6:0];
          REG_BASE_NOTE:     base_reg   = cfg_data[6:0];
          REG_SAMPLE_LENGTH: length_reg = cfg_data;
          REG_SOUND_ENABLE:  enable_reg = cfg_data[0];
          default: ;
        endcase
      end

      // Input beat: update the shadow voice and queue any result.
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          OP_WRITE: begin
            if (in_tdata[11:0] < DEPTH) wave_mem[in_tdata[11:0]] = in_tdata[27:12];
          end
          OP_TRIGGER: begin
            if (enable_reg) play_pos = '0;
          end
          OP_RENDER: begin
            len = (length_reg > DEPTH) ? DEPTH : 32'(length_reg);
            idx = 32'(play_pos[31:16]);
            if (len < 2 || idx >= len - 1) begin
              voice_q.push_back('{audio: '0, playing: 1'b0});
            end else begin
              voice_q.push_back('{audio: blend(wave_mem[idx], wave_mem[idx + 1],
                                               play_pos[15:0]),
                                  playing: 1'b1});
              play_pos += pitch_step(pitch_reg, base_reg);
            end
          end
          default: ;
        endcase
      end
    end
    pending = voice_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the sample player: clock, reset, stimulus and the final verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pspu_pkg::*;

  // Operation code that the block has no use for.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_LENGTH = 8191;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [11:0] sample_address, [27:12] sample_value
  logic [1:0]  in_tuser = '0;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] audio_sample
  logic        out_tuser;       // [0] playing
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  bit          quiet_tx = 1'b0;
  bit          quiet_rx = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pitched_sample_player_unit u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pspu_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // Watchdog on the overall run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pitched_sample_player_unit test failed");
      $finish;
    end
  end

  // Result side: a random stall before each beat is taken.
  always begin
    int stall;
    @(negedge clk);
    stall = quiet_rx ? 0 : $urandom_range(0, 10);
    if (stall > 0) begin
      out_tready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_tready <= 1'b1;
    @(posedge clk);
    while (!out_tvalid) @(posedge clk);
  end

  // One input beat after a random gap; returns at the edge that accepts it.
  task automatic send_beat(logic [1:0] op, logic [11:0] addr, logic [15:0] value);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, value, addr};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every result is back and the pipeline is empty.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(pspu_reg_t idx, logic [12:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Notes lean towards the ends of the range so the octave clamp is exercised.
  function automatic logic [6:0] pick_note();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 7'd127 : 7'd0;
    return 7'($urandom_range(0, 127));
  endfunction

  initial begin
    int unsigned roll;
    int unsigned trig_pct;
    logic [6:0]  pitch;
    logic [6:0]  base;
    logic [12:0] len;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the whole store first so no render ever reads an unwritten word.
    quiet_tx = 1'b1;
    for (int a = 0; a < SAMPLE_DEPTH_DEF; a++) send_beat(OP_WRITE, 12'(a), 16'($urandom));
    settle();
    quiet_tx = 1'b0;

    // Zero length after reset, then a single word: both stay silent.
    send_beat(OP_RENDER, 12'h000, 16'h0000);
    send_beat(OP_TRIGGER, 12'hfff, 16'hffff);
    send_beat(OP_RENDER, 12'h000, 16'h0000);
    settle();
    write_reg(REG_SAMPLE_LENGTH, 13'd1);
    send_beat(OP_RENDER, 12'hfff, 16'hffff);
    settle();

    // Length above the store depth, top of the upward octave clamp, extreme words.
    write_reg(REG_SAMPLE_LENGTH, 13'(MAX_LENGTH));
    write_reg(REG_PITCH_NOTE, 13'd127);
    write_reg(REG_BASE_NOTE, 13'd0);
    send_beat(OP_WRITE, 12'd0, 16'h8000);
    send_beat(OP_WRITE, 12'd1, 16'h7fff);
    send_beat(OP_WRITE, 12'd4095, 16'h7fff);
    send_beat(OP_WRITE, 12'd4094, 16'h8000);
    send_beat(OP_TRIGGER, 12'd0, 16'h0000);
    send_beat(OP_RENDER, 12'd0, 16'h0000);
    send_beat(OP_RENDER, 12'd0, 16'h0000);
    send_beat(OP_UNUSED, 12'hfff, 16'hffff);
    send_beat(OP_RENDER, 12'd0, 16'h0000);
    settle();

    // Bottom of the downward clamp; a trigger while sound is off is dropped.
    write_reg(REG_PITCH_NOTE, 13'd0);
    write_reg(REG_BASE_NOTE, 13'd127);
    write_reg(REG_SOUND_ENABLE, 13'd0);
    send_beat(OP_TRIGGER, 12'd0, 16'h0000);
    send_beat(OP_RENDER, 12'd0, 16'h0000);
    settle();
    write_reg(REG_SOUND_ENABLE, 13'd1);

    // Slow playback over the full-scale rise, then rewritten words take effect at once.
    send_beat(OP_TRIGGER, 12'd0, 16'h0000);
    repeat (4) send_beat(OP_RENDER, 12'd0, 16'h0000);
    send_beat(OP_WRITE, 12'd0, 16'h7fff);
    send_beat(OP_WRITE, 12'd1, 16'h8000);
    send_beat(OP_RENDER, 12'd0, 16'h0000);
    send_beat(OP_RENDER, 12'd0, 16'h0000);
    settle();

    // Random phases: new settings each time, then mostly trigger-and-render runs.
    for (int phase = 0; phase < 20; phase++) begin
      pitch = pick_note();
      base  = ($urandom_range(0, 5) == 0) ? pitch : pick_note();
      roll  = $urandom_range(0, 19);
      if (roll < 2) len = 13'($urandom_range(0, 1));
      else if (roll < 4) len = 13'(SAMPLE_DEPTH_DEF);
      else if (roll < 5) len = 13'($urandom_range(SAMPLE_DEPTH_DEF + 1, MAX_LENGTH));
      else if (roll < 7) len = 13'($urandom_range(2, SAMPLE_DEPTH_DEF));
      else len = 13'($urandom_range(2, 40));
      write_reg(REG_PITCH_NOTE, 13'(pitch));
      write_reg(REG_BASE_NOTE, 13'(base));
      write_reg(REG_SAMPLE_LENGTH, len);
      write_reg(REG_SOUND_ENABLE, 13'($urandom_range(0, 6) != 0));
      quiet_tx = ($urandom_range(0, 3) == 0);
      quiet_rx = ($urandom_range(0, 3) == 0);
      trig_pct = $urandom_range(2, 15);

      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(0, 99);
        if (n == 50 && $urandom_range(0, 3) == 0) settle();
        if (roll < trig_pct) begin
          send_beat(OP_TRIGGER, 12'($urandom), 16'($urandom));
        end else if (roll < trig_pct + 14) begin
          send_beat(OP_WRITE, 12'($urandom), 16'($urandom));
        end else if (roll < trig_pct + 18) begin
          send_beat(OP_UNUSED, 12'($urandom), 16'($urandom));
        end else begin
          send_beat(OP_RENDER, 12'($urandom), 16'($urandom));
        end
      end
      settle();
    end

    quiet_rx = 1'b0;
    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("pitched_sample_player_unit test passed");
    end else begin
      $display("pitched_sample_player_unit test failed");
    end
    $finish;
  end

endmodule

// ===== pitched_sample_player_unit.f =====
+incdir+rtl/core
rtl/core/pspu_pkg.sv
rtl/core/pspu_store.sv
rtl/core/pspu_interp.sv
rtl/core/pspu_ctrl.sv
rtl/core/pitched_sample_player_unit.sv
dv/pspu_checker.sv
dv/tb_top.sv
